@@ design/lis_pkg.sv @@
// shared types for the patience-sorting subsequence length block
package lis_pkg;

    // per-cell status handed to the neighbour and to the top level
    typedef struct packed {
        logic valid;   // cell holds a tail
        logic less;    // held tail is strictly less than the current key
        logic append;  // cell takes the key while empty
    } lis_cell_status_t;

endpackage

@@ design/lis_in_if.sv @@
// input channel: one sequence element per beat
interface lis_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

@@ design/lis_out_if.sv @@
// output channel: one length result per beat
interface lis_out_if #(
    parameter int LEN_WIDTH = 9
);
    logic                 valid;
    logic                 ready;
    logic [LEN_WIDTH-1:0] lis_length;
    logic                 overflow;
    logic                 is_last;

    modport source (output valid, output lis_length, output overflow, output is_last,
                    input ready);
    modport sink   (input valid, input lis_length, input overflow, input is_last,
                    output ready);
endinterface

@@ design/lis_length_patience.sv @@
// top level: streaming longest strictly increasing subsequence length
//
// items (sink): one signed value per beat, with last marking the end of a sequence.
// results (source): exactly one beat per item, carrying the subsequence length after
// that item, the sticky overflow flag and an echo of last.
// the tails live in a row of MAX_LEN cells; every cell compares the key with its own
// tail and passes a "below key" bit to its right-hand neighbour, so the replace or
// append position is decided in the same cycle the item is accepted.
// output: an accepted item's result sits in the output register from the next cycle.
// throughput: one item per cycle while results are taken, set by the single compare in each
// cell and the or-reduction of the append bits feeding the length counter.
// stall: the output register holds its beat while results.ready is low; items.ready
// follows results.ready in that case, so no result is ever lost or repeated.
// reset: all cell valid bits, the length counter and the overflow flag clear at once,
// with no clearing pass; tail values themselves are not reset.
// after the beat with last set, the chain and counters return to the empty state.
// once MAX_LEN tails are held, a value larger than all of them is dropped and the
// overflow flag stays set until the end of the sequence.
module lis_length_patience #(
    parameter int MAX_LEN    = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    lis_in_if.sink     items,
    lis_out_if.source  results
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    // order key: flipping the sign bit makes signed values compare as unsigned
    logic [DATA_WIDTH-1:0] key;
    logic                  accept;

    lis_pkg::lis_cell_status_t cell_status [MAX_LEN];
    logic [MAX_LEN-1:0]        valid_vec;
    logic [MAX_LEN-1:0]        append_vec;
    logic                      append_any;
    logic                      drop;

    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic [LEN_W-1:0] length_now;
    logic             overflowed_reg;
    logic             overflowed_next;
    logic             overflow_now;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;

    assign key    = {~items.value[DATA_WIDTH-1], items.value[DATA_WIDTH-2:0]};
    // take a new beat whenever the output register is empty or being drained
    assign items.ready = !out_valid_reg || results.ready;
    assign accept      = items.valid && items.ready;

    // the chain of cells
    genvar i;
    generate
        for (i = 0; i < MAX_LEN; i++)
        begin : g_cell
            logic prev_less;
            if (i == 0)
            begin : g_head
                assign prev_less = 1'b1;
            end
            else
            begin : g_body
                assign prev_less = cell_status[i-1].less;
            end

            lis_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .step      (accept),
                .clear     (items.last),
                .key       (key),
                .prev_less (prev_less),
                .status    (cell_status[i])
            );

            assign valid_vec[i]  = cell_status[i].valid;
            assign append_vec[i] = cell_status[i].append;
        end
    endgenerate

    assign append_any = |append_vec;
    // every tail below the key and no free cell left: the value is dropped
    assign drop       = cell_status[MAX_LEN-1].less;

    assign length_now   = count_reg + LEN_W'(append_any);
    assign overflow_now = overflowed_reg || drop;

    always_comb
    begin
        count_next      = count_reg;
        overflowed_next = overflowed_reg;
        if (accept)
        begin
            if (items.last)
            begin
                count_next      = '0;
                overflowed_next = 1'b0;
            end
            else
            begin
                count_next      = length_now;
                overflowed_next = overflow_now;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            overflowed_reg <= overflowed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_len_reg  <= length_now;
            out_ovf_reg  <= overflow_now;
            out_last_reg <= items.last;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.lis_length = out_len_reg;
    assign results.overflow   = out_ovf_reg;
    assign results.is_last    = out_last_reg;

    // the length counter tracks the number of occupied cells
    a_count_matches_cells : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == LEN_W'($countones(valid_vec)))
        else $error("length counter out of step with cell valid bits");

    // a dropped value is only possible with a full chain
    a_overflow_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (count_reg == LEN_W'(MAX_LEN)))
        else $error("overflow flagged below capacity");

    // an accepted item always leaves a result in the output register
    a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

endmodule

@@ design/lis_cell.sv @@
// one cell of the tails chain: holds a single tail and its valid bit
module lis_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,       // an input beat is accepted
    input  logic                          clear,      // the accepted beat ends the sequence
    input  logic [DATA_WIDTH-1:0]         key,        // order key, sign bit flipped
    input  logic                          prev_less,  // every tail to the left is below key
    output lis_pkg::lis_cell_status_t     status
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] tail_reg;
    logic                  less;
    logic                  take;

    // tails are sorted, so the first tail not below key sits right after a smaller one
    assign less = valid_reg && (tail_reg < key);
    assign take = prev_less && !less;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            if (clear)
            begin
                valid_next = 1'b0;
            end
            else if (take)
            begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && take)
        begin
            tail_reg <= key;
        end
    end

    assign status.valid  = valid_reg;
    assign status.less   = less;
    assign status.append = take && !valid_reg;

endmodule

@@ sim/lis_length_patience_tb.sv @@
// testbench for the streaming patience-sorting subsequence length block
`timescale 1ns / 100ps

module lis_length_patience_tb;

    localparam int MAX_LEN      = 256;
    localparam int DATA_WIDTH   = 32;
    localparam int LEN_WIDTH    = 9;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 2;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int SETTLE_WAIT  = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

    // how a short random sequence picks its values
    typedef enum int {
        SEQ_WIDE,      // anywhere in the full signed range
        SEQ_NARROW,    // a handful of small values, lots of equal tails
        SEQ_EXTREME,   // range ends and values around zero
        SEQ_RISING     // noisy upward trend, grows long subsequences
    } seq_style_t;

    // one expected result beat
    typedef struct packed {
        logic [LEN_WIDTH-1:0] lis_length;
        logic                 overflow;
        logic                 is_last;
    } lis_result_t;

    // tracks the tails array of the current sequence and the results still owed
    class patience_board;
        logic signed [DATA_WIDTH-1:0] tails [MAX_LEN];
        int          tail_cnt;
        bit          seq_overflow;
        lis_result_t owed_results[$];
        int          mismatches;
        int          results_seen;
        int          sequences_done;
        int          overflowed_seqs;

        function new();
            tail_cnt        = 0;
            seq_overflow    = 0;
            mismatches      = 0;
            results_seen    = 0;
            sequences_done  = 0;
            overflowed_seqs = 0;
        endfunction

        // accepted input beat: update the tails and queue the length it yields
        function void note_item(logic signed [DATA_WIDTH-1:0] value, logic last);
            int          pos;
            lis_result_t res;
            pos = 0;
            // first tail that is not below the value
            while (pos < tail_cnt && tails[pos] < value)
                pos++;
            if (pos < tail_cnt)
                tails[pos] = value;
            else if (tail_cnt < MAX_LEN)
            begin
                tails[tail_cnt] = value;
                tail_cnt++;
            end
            else
                seq_overflow = 1'b1;
            res.lis_length = LEN_WIDTH'(tail_cnt);
            res.overflow   = seq_overflow;
            res.is_last    = last;
            owed_results.insert(owed_results.size(), res);
            if (last)
            begin
                sequences_done++;
                if (seq_overflow)
                    overflowed_seqs++;
                tail_cnt     = 0;
                seq_overflow = 1'b0;
            end
        endfunction

        // accepted result beat: compare with the oldest owed result
        function void check_result(logic [LEN_WIDTH-1:0] lis_length, logic overflow,
                                   logic is_last);
            lis_result_t want;
            results_seen++;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: result with none owed, len=%0d ovf=%0b last=%0b",
                             lis_length, overflow, is_last);
                return;
            end
            want = owed_results.pop_front();
            if (lis_length !== want.lis_length || overflow !== want.overflow ||
                is_last !== want.is_last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch at result %0d: len %0d/%0d ovf %0b/%0b last %0b/%0b",
                             results_seen, want.lis_length, lis_length, want.overflow,
                             overflow, want.is_last, is_last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lis_in_if  #(.DATA_WIDTH(DATA_WIDTH)) items_if ();
    lis_out_if #(.LEN_WIDTH(LEN_WIDTH))   results_if ();

    lis_length_patience #(
        .MAX_LEN    (MAX_LEN),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if.sink),
        .results (results_if.source)
    );

    patience_board board = new();

    int tx_idle_pct;   // chance per beat that the sender holds off
    int rx_idle_pct;   // chance per cycle that the receiver stalls
    int items_sent;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lis_length_patience_tb: errors");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        results_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // input side monitor: every accepted beat feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && items_if.valid && items_if.ready)
            board.note_item(items_if.value, items_if.last);
    end

    // output side monitor: every accepted beat is checked in order
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            board.check_result(results_if.lis_length, results_if.overflow,
                               results_if.is_last);
    end

    // one beat on the input channel, with random hold-off in front of it;
    // valid stays high into the next beat unless the next call idles first
    task automatic send_item(input logic signed [DATA_WIDTH-1:0] value, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.value <= value;
        items_if.last  <= last;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // sender goes quiet until every owed result has come back;
    // the task waits on the clock before checking, so valid is never lowered and raised in one step
    task automatic hold_until_drained();
        items_if.valid <= 1'b0;
        @(posedge clk);
        while (board.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // hand-picked beats: range ends, equal values, falling and rising runs,
    // single-beat sequences and alternating bit patterns
    task automatic run_directed();
        send_item(32'sd0, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);          // replaces the zero tail
        send_item(VAL_MIN, 1'b0);          // equal to a tail, no growth
        send_item(-32'sd1, 1'b0);          // replaces the max tail
        send_item(32'sd0, 1'b0);
        send_item(32'sd0, 1'b1);           // equal again, sequence ends
        send_item(VAL_MIN, 1'b1);          // one-beat sequence
        send_item(32'sd5, 1'b0);
        send_item(32'sd4, 1'b0);
        send_item(32'sd3, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd1, 1'b1);           // strictly falling, length stays one
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MIN + 32'sd1, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(VAL_MAX - 32'sd1, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b1);          // equal to the top tail at the end
    endtask

    // short sequence of random length, always closed by a last beat
    task automatic send_random_seq();
        int                           len;
        seq_style_t                   style;
        logic signed [DATA_WIDTH-1:0] value;
        logic signed [DATA_WIDTH-1:0] trend;
        len   = $urandom_range(1, 40);
        style = seq_style_t'($urandom_range(SEQ_RISING));
        trend = $urandom;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                SEQ_WIDE:    value = $urandom;
                SEQ_NARROW:  value = $signed($urandom_range(16)) - 32'sd8;
                SEQ_EXTREME:
                begin
                    case ($urandom_range(5))
                        0:       value = VAL_MIN;
                        1:       value = VAL_MIN + 32'sd1;
                        2:       value = VAL_MAX;
                        3:       value = VAL_MAX - 32'sd1;
                        4:       value = -32'sd1;
                        default: value = 32'sd0;
                    endcase
                end
                default:
                begin
                    // mostly climbing, occasionally dipping; wraps at the top end
                    trend = trend + $signed($urandom_range(1000)) - 32'sd200;
                    value = trend;
                end
            endcase
            send_item(value, (i == len - 1));
        end
    endtask

    // long mostly-rising sequence that fills every tail; with extra set it
    // keeps appending past capacity so the drop flag must stick
    task automatic send_capacity_seq(input int extra);
        longint climb;
        int     grown;
        int     tail_beats;
        climb = -64'sd2147483648 + 64'sd2097152 + $urandom_range(1000);
        grown = 0;
        while (grown < MAX_LEN + extra)
        begin
            if (grown > 0 && $urandom_range(7) == 0)
            begin
                // at or below the newest tail: a replacement, never an append
                send_item(DATA_WIDTH'(climb - $urandom_range(1 << 20)), 1'b0);
            end
            else
            begin
                climb = climb + $urandom_range(1, 1 << 20);
                send_item(DATA_WIDTH'(climb), 1'b0);
                grown++;
            end
        end
        if (extra > 0)
        begin
            // random values once full: big ones drop, small ones still replace
            tail_beats = $urandom_range(4, 12);
            for (int i = 0; i < tail_beats; i++)
                send_item($urandom, 1'b0);
            send_item(VAL_MIN, 1'b1);
        end
        else
        begin
            // equal to the top tail, so the length ends at exactly capacity
            send_item(DATA_WIDTH'(climb), 1'b1);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        items_if.valid   = 1'b0;
        items_if.value   = '0;
        items_if.last    = 1'b0;
        tx_idle_pct      = 34;
        rx_idle_pct      = 46;
        items_sent       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        hold_until_drained();

        // phase one: sender idles less than the receiver stalls
        send_capacity_seq(0);
        while (items_sent < 330)
            send_random_seq();
        hold_until_drained();

        // phase two: the other way round
        tx_idle_pct = 46;
        rx_idle_pct = 34;
        while (items_sent < 620)
            send_random_seq();
        hold_until_drained();

        // phase three: both sides flat out, overflow past capacity
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_capacity_seq($urandom_range(3, 12));
        while (items_sent < 950)
            send_random_seq();
        hold_until_drained();

        repeat (SETTLE_WAIT) @(posedge clk);

        if (board.owed_results.size() != 0)
            board.mismatches++;

        $display("run covered %0d beats in %0d sequences, %0d results checked",
                 items_sent, board.sequences_done, board.results_seen);
        $display("%0d sequences ran past capacity, %0d mismatches",
                 board.overflowed_seqs, board.mismatches);
        if (board.mismatches == 0)
            $display("lis_length_patience_tb: clean");
        else
            $display("lis_length_patience_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
design/lis_pkg.sv
design/lis_in_if.sv
design/lis_out_if.sv
design/lis_cell.sv
design/lis_length_patience.sv
sim/lis_length_patience_tb.sv
